[rtl/tic_pkg.sv]
// Shared types and constants of the triangular inverse CDF unit.
package tic_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_MODE  = 2'd1;
  localparam logic [1:0] CFG_UPPER = 2'd2;

  // Reset values of the bounds, signed Q16.16.
  localparam logic [31:0] LOWER_RST = 32'hFFFF_0000;
  localparam logic [31:0] MODE_RST  = 32'h0000_0000;
  localparam logic [31:0] UPPER_RST = 32'h0001_0000;

  // 1.0 in unsigned Q0.32.
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Pipeline layout: six front stages, the root stages, one output stage.
  localparam int FRONT_STAGES = 6;
  localparam int SQRT_STAGES  = 16;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + 1;
  localparam int OUT_IDX      = PIPE_DEPTH - 1;

  // Working pair of the restoring square root.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  // One restoring step; step 0 tests the bit of weight 2^62.
  function automatic sq_t sqrt_step(sq_t cur, logic [4:0] step);
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_t         nxt;
    bitv  = 64'd1 << (6'd62 - {step, 1'b0});
    trial = cur.root + bitv;
    if (cur.rem >= trial) begin
      nxt.rem  = cur.rem - trial;
      nxt.root = (cur.root >> 1) + bitv;
    end else begin
      nxt.rem  = cur.rem;
      nxt.root = cur.root >> 1;
    end
    return nxt;
  endfunction

endpackage

[rtl/triangular_inverse_cdf_unit.sv]
// Triangular inverse CDF unit: one quantile per probability word, fully pipelined.
// A word passes through 23 registered stages, from the input stage to the output stage.
// Throughput: one word per cycle while out_stall_i is low; the 16 root stages of two bits each set the depth.
// Every stage holds a valid bit and loads when it is empty or its successor moves,
// so bubbles close up and input is taken while a finished word waits.
// Reset clears the valid bits and sets the bounds to a = -1.0, m = 0, b = +1.0.
module triangular_inverse_cdf_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] prob_i,
  input  logic        upper_tail_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sample_value_o,
  output logic        config_error_o
);
  import tic_pkg::*;

  localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

  // Configuration registers.
  logic signed [31:0] cfg_lower_q, cfg_mode_q, cfg_upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_lower_q <= LOWER_RST;
      cfg_mode_q  <= MODE_RST;
      cfg_upper_q <= UPPER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOWER: cfg_lower_q <= cfg_data_i;
        CFG_MODE:  cfg_mode_q  <= cfg_data_i;
        CFG_UPPER: cfg_upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables.
  logic [PIPE_DEPTH-1:0] valid_q;
  logic [PIPE_DEPTH-1:0] stage_en;

  always_comb begin
    stage_en[OUT_IDX] = !valid_q[OUT_IDX] || !out_stall_i;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) valid_q[0] <= in_valid_i;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (stage_en[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  assign in_stall_o = !stage_en[0];

  // Stage 0: input word.
  logic [31:0] s0_prob_q;
  logic        s0_tail_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s0_prob_q <= prob_i;
      s0_tail_q <= upper_tail_i;
    end
  end

  // Stage 1: spans of the configuration and its check.
  logic [31:0]        s1_ba_q, s1_ma_q, s1_bm_q, s1_prob_q;
  logic signed [31:0] s1_lower_q, s1_upper_q;
  logic               s1_tail_q, s1_err_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s1_ba_q    <= cfg_upper_q - cfg_lower_q;
      s1_ma_q    <= cfg_mode_q - cfg_lower_q;
      s1_bm_q    <= cfg_upper_q - cfg_mode_q;
      s1_err_q   <= (cfg_lower_q >= cfg_upper_q) || (cfg_mode_q < cfg_lower_q) ||
                    (cfg_mode_q > cfg_upper_q);
      s1_lower_q <= cfg_lower_q;
      s1_upper_q <= cfg_upper_q;
      s1_prob_q  <= s0_prob_q;
      s1_tail_q  <= s0_tail_q;
    end
  end

  // Stage 2: the three products.
  logic [63:0]        s2_bap_q, s2_wma_q, s2_wbm_q;
  logic [31:0]        s2_ma_q, s2_bm_q, s2_prob_q;
  logic signed [31:0] s2_lower_q, s2_upper_q;
  logic               s2_tail_q, s2_err_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      s2_bap_q   <= 64'(s1_ba_q) * 64'(s1_prob_q);
      s2_wma_q   <= 64'(s1_ba_q) * 64'(s1_ma_q);
      s2_wbm_q   <= 64'(s1_ba_q) * 64'(s1_bm_q);
      s2_ma_q    <= s1_ma_q;
      s2_bm_q    <= s1_bm_q;
      s2_prob_q  <= s1_prob_q;
      s2_lower_q <= s1_lower_q;
      s2_upper_q <= s1_upper_q;
      s2_tail_q  <= s1_tail_q;
      s2_err_q   <= s1_err_q;
    end
  end

  // Stage 3: pick the branch, its weight and its product.
  logic        s3_left_d;
  logic [32:0] s3_q_d, prob_inv;

  always_comb begin
    prob_inv = ONE_Q32 - {1'b0, s2_prob_q};
    if (s2_tail_q) s3_left_d = {s2_bm_q, 32'd0} < s2_bap_q;
    else           s3_left_d = s2_bap_q < {s2_ma_q, 32'd0};
    if (s3_left_d == s2_tail_q) s3_q_d = prob_inv;
    else                        s3_q_d = {1'b0, s2_prob_q};
  end

  logic [32:0]        s3_q_q;
  logic [63:0]        s3_w_q;
  logic signed [31:0] s3_base_q;
  logic               s3_left_q, s3_err_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      s3_q_q    <= s3_q_d;
      s3_w_q    <= s3_left_d ? s2_wma_q : s2_wbm_q;
      s3_base_q <= s3_left_d ? s2_lower_q : s2_upper_q;
      s3_left_q <= s3_left_d;
      s3_err_q  <= s2_err_q;
    end
  end

  // Stage 4: partial products of weight times product.
  logic [63:0]        s4_ph_q, s4_pl_q, s4_w_q;
  logic               s4_full_q, s4_left_q, s4_err_q;
  logic signed [31:0] s4_base_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      s4_ph_q   <= 64'(s3_q_q[31:0]) * 64'(s3_w_q[63:32]);
      s4_pl_q   <= 64'(s3_q_q[31:0]) * 64'(s3_w_q[31:0]);
      s4_w_q    <= s3_w_q;
      s4_full_q <= s3_q_q[32];
      s4_left_q <= s3_left_q;
      s4_base_q <= s3_base_q;
      s4_err_q  <= s3_err_q;
    end
  end

  // Stage 5: radicand, floored to Q0.32 weight.
  logic [63:0]        s5_rad_q;
  logic               s5_left_q, s5_err_q;
  logic signed [31:0] s5_base_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      s5_rad_q  <= s4_full_q ? s4_w_q : s4_ph_q + {32'd0, s4_pl_q[63:32]};
      s5_left_q <= s4_left_q;
      s5_base_q <= s4_base_q;
      s5_err_q  <= s4_err_q;
    end
  end

  // Root stages, two result bits each.
  sq_t                sq_q    [SQRT_STAGES];
  logic               sq_left_q [SQRT_STAGES];
  logic               sq_err_q  [SQRT_STAGES];
  logic signed [31:0] sq_base_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    sq_t                sq_in, sq_mid;
    logic               left_in, err_in;
    logic signed [31:0] base_in;

    if (k == 0) begin : g_first
      assign sq_in   = '{rem: s5_rad_q, root: 64'd0};
      assign left_in = s5_left_q;
      assign err_in  = s5_err_q;
      assign base_in = s5_base_q;
    end else begin : g_next
      assign sq_in   = sq_q[k-1];
      assign left_in = sq_left_q[k-1];
      assign err_in  = sq_err_q[k-1];
      assign base_in = sq_base_q[k-1];
    end

    assign sq_mid = sqrt_step(sq_in, 5'(2 * k));

    always_ff @(posedge clk_i) begin
      if (stage_en[FRONT_STAGES + k]) begin
        sq_q[k]      <= sqrt_step(sq_mid, 5'(2 * k + 1));
        sq_left_q[k] <= left_in;
        sq_err_q[k]  <= err_in;
        sq_base_q[k] <= base_in;
      end
    end
  end

  // Output stage: add or subtract the root and saturate; a config error gives a zero sample.
  logic signed [33:0] base_ext, root_ext, sum;
  logic [31:0]        sample_d;

  always_comb begin
    base_ext = 34'(sq_base_q[SQRT_STAGES-1]);
    root_ext = $signed({2'b00, sq_q[SQRT_STAGES-1].root[31:0]});
    sum      = sq_left_q[SQRT_STAGES-1] ? base_ext + root_ext : base_ext - root_ext;
    if (sq_err_q[SQRT_STAGES-1]) sample_d = '0;
    else if (sum > SAT_MAX)      sample_d = SAT_MAX[31:0];
    else if (sum < SAT_MIN)      sample_d = SAT_MIN[31:0];
    else                         sample_d = sum[31:0];
  end

  logic [31:0] out_sample_q;
  logic        out_err_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[OUT_IDX]) begin
      out_sample_q <= sample_d;
      out_err_q    <= sq_err_q[SQRT_STAGES-1];
    end
  end

  assign out_valid_o    = valid_q[OUT_IDX];
  assign sample_value_o = out_sample_q;
  assign config_error_o = out_err_q;

  // A bad configuration yields a zero sample.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && config_error_o |-> sample_value_o == '0)
    else $error("config error word carries a nonzero sample");

  // Input is held off only when every stage is full and the output is stalled.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  // A good configuration keeps the sample between the bounds.
  a_in_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !config_error_o |->
      $signed(sample_value_o) >= cfg_lower_q && $signed(sample_value_o) <= cfg_upper_q)
    else $error("sample outside the configured bounds");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the triangular inverse CDF unit with its own quantile predictor.
module testbench;
  import tic_pkg::*;

  localparam logic [1:0]  CFG_SPARE    = 2'd3;
  localparam int          BOUND_SETS   = 12;
  localparam int          WORDS_PER_SET = 75;
  localparam int          DRAIN_CYCLES = 30;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [31:0] S32_MIN      = 32'h8000_0000;
  localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] sample;
    logic        cfg_err;
  } quantile_t;

  class quantile_checker;
    logic [31:0] lo_q;
    logic [31:0] mode_q;
    logic [31:0] hi_q;
    quantile_t   pending_quantiles[$];
    int          mismatches;

    function new();
      lo_q       = LOWER_RST;
      mode_q     = MODE_RST;
      hi_q       = UPPER_RST;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_LOWER: lo_q = data;
        CFG_MODE:  mode_q = data;
        CFG_UPPER: hi_q = data;
        default: ;
      endcase
    endfunction

    function bit bad_bounds();
      return $signed(lo_q) >= $signed(hi_q) || $signed(mode_q) < $signed(lo_q) ||
             $signed(mode_q) > $signed(hi_q);
    endfunction

    function logic [31:0] floor_sqrt(logic [63:0] x);
      logic [31:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        c = {32'd0, r | (32'd1 << i)};
        if (c * c <= x) r = c[31:0];
      end
      return r;
    endfunction

    // Probability at which the quantile moves from one side of the mode to the other.
    function logic [31:0] split_point(logic tail);
      logic signed [63:0] a, m, b;
      logic [63:0]        span, part, quo;
      if (bad_bounds()) return '0;
      a    = {{32{lo_q[31]}}, lo_q};
      m    = {{32{mode_q[31]}}, mode_q};
      b    = {{32{hi_q[31]}}, hi_q};
      span = b - a;
      part = tail ? b - m : m - a;
      quo  = (part << 32) / span;
      return (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    function quantile_t predict(logic [31:0] p, logic tail);
      logic signed [63:0] a, m, b, res;
      logic [63:0]        span, below, above, w, rad;
      logic [32:0]        q;
      logic [96:0]        prod;
      logic [31:0]        root;
      logic               left;
      quantile_t          r;
      r.sample  = '0;
      r.cfg_err = 1'b1;
      if (bad_bounds()) return r;
      a     = {{32{lo_q[31]}}, lo_q};
      m     = {{32{mode_q[31]}}, mode_q};
      b     = {{32{hi_q[31]}}, hi_q};
      span  = b - a;
      below = m - a;
      above = b - m;
      if (tail) left = (above << 32) < span * {32'd0, p};
      else      left = span * {32'd0, p} < (below << 32);
      // The weight is p on the side the tail points to, and 1 - p on the other.
      q    = (left != tail) ? {1'b0, p} : ONE_Q32 - {1'b0, p};
      w    = left ? span * below : span * above;
      prod = q * w;
      rad  = prod[95:32];
      root = floor_sqrt(rad);
      res  = left ? a + $signed({32'd0, root}) : b - $signed({32'd0, root});
      if (res > 64'sd2147483647)       r.sample = S32_MAX;
      else if (res < -64'sd2147483648) r.sample = S32_MIN;
      else                             r.sample = res[31:0];
      r.cfg_err = 1'b0;
      return r;
    endfunction

    function void record_probability(logic [31:0] p, logic tail);
      pending_quantiles.push_back(predict(p, tail));
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function void check_sample(logic [31:0] sample, logic err);
      quantile_t e;
      if (pending_quantiles.size() == 0) begin
        flag($sformatf("unexpected word, sample %h error %b", sample, err));
        return;
      end
      e = pending_quantiles.pop_front();
      if (e.sample !== sample)
        flag($sformatf("sample expected %h got %h", e.sample, sample));
      if (e.cfg_err !== err)
        flag($sformatf("config_error expected %b got %b", e.cfg_err, err));
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = CFG_LOWER;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [31:0] prob_i         = '0;
  logic        upper_tail_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [31:0] sample_value_o;
  logic        config_error_o;

  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              cycle_count    = 0;
  quantile_checker checker_q;

  triangular_inverse_cdf_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .prob_i         (prob_i),
    .upper_tail_i   (upper_tail_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_value_o (sample_value_o),
    .config_error_o (config_error_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      checker_q.check_sample(sample_value_o, config_error_o);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // Valid is left high so that a following word can go out back to back.
  task automatic drive_probability(logic [31:0] p, logic tail);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    prob_i       <= p;
    upper_tail_i <= tail;
    do @(posedge clk_i); while (in_stall_o);
    checker_q.record_probability(p, tail);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    checker_q.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_bounds(logic [31:0] a, logic [31:0] m, logic [31:0] b);
    write_register(CFG_LOWER, a);
    write_register(CFG_MODE, m);
    write_register(CFG_UPPER, b);
    // The spare index must not disturb any bound.
    write_register(CFG_SPARE, $urandom);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic choose_bounds(int set_idx);
    logic signed [31:0] v0, v1, v2, t;
    int                 width;
    v0 = $urandom;
    v1 = $urandom;
    v2 = $urandom;
    if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
    if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    case (set_idx)
      1:  set_bounds(S32_MIN, S32_MIN, S32_MAX);
      2:  set_bounds(S32_MIN, S32_MAX, S32_MAX);
      4:  begin
        // Broken bounds: equal limits, mode below a, or mode above b.
        case ($urandom_range(0, 2))
          0:       set_bounds(v1, v1, v1);
          1:       set_bounds(v1, v0, v2);
          default: set_bounds(v0, v2, v1);
        endcase
      end
      5, 10: begin
        width = (set_idx == 10) ? 1 : $urandom_range(1, 16);
        t = $signed($urandom) >>> 1;
        set_bounds(t, t + $urandom_range(0, width), t + width);
      end
      6:  set_bounds(v0, v0, v2);
      7:  set_bounds(v2, v1, v0);
      9:  set_bounds(S32_MIN, '0, S32_MAX);
      11: set_bounds(v0, v2, v2);
      default: set_bounds(v0, v1, v2);
    endcase
  endtask

  function automatic logic [31:0] random_prob(logic tail);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 255);
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      4, 5:    return checker_q.split_point(tail) + $urandom_range(0, 8) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_probs[8];
    logic        tail;
    checker_q  = new();
    edge_probs = '{32'h0000_0000, 32'h0000_0001, 32'h4000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int s = 0; s < BOUND_SETS; s++) begin
      send_idle_pct  = (s < 4) ? 35 : (s < 8) ? 62 : 0;
      recv_stall_pct = (s < 4) ? 62 : (s < 8) ? 35 : 0;
      if (s > 0) begin
        choose_bounds(s);
      end else begin
        // With the reset bounds the split sits exactly at one half.
        foreach (edge_probs[i]) begin
          drive_probability(edge_probs[i], 1'b0);
          drive_probability(edge_probs[i], 1'b1);
        end
      end
      for (int k = 0; k < WORDS_PER_SET; k++) begin
        tail = $urandom_range(0, 1);
        drive_probability(random_prob(tail), tail);
      end
      in_valid_i <= 1'b0;
      while (checker_q.pending_quantiles.size() != 0) @(negedge clk_i);
      repeat (DRAIN_CYCLES) @(negedge clk_i);
    end

    if (checker_q.mismatches == 0 && checker_q.pending_quantiles.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
